[sv/lacc_pkg.sv]
// Shared constants, types and helper functions for the access code correlator.
package lacc_pkg;

    // History / code geometry
    localparam int CODE_WORDS  = 4;
    localparam int REG_WORDS   = 4;
    localparam int WORD_BITS   = 64;
    localparam int HIST_BITS   = CODE_WORDS * WORD_BITS;
    localparam int CHUNK_BITS  = 16;
    localparam int NUM_CHUNKS  = HIST_BITS / CHUNK_BITS;
    localparam int CHUNK_CNT_W = $clog2(CHUNK_BITS + 1);
    localparam int CNT_W       = $clog2(HIST_BITS + 1);

    // Register port geometry
    localparam int LEN_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = WORD_BITS;

    // Reset values
    localparam logic [LEN_W-1:0] CODE_LENGTH_RST     = LEN_W'(64);
    localparam logic [LEN_W-1:0] MATCH_THRESHOLD_RST = '0;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_WORD_0     = 3'd0,
        REG_CODE_WORD_1     = 3'd1,
        REG_CODE_WORD_2     = 3'd2,
        REG_CODE_WORD_3     = 3'd3,
        REG_CODE_LENGTH     = 3'd4,
        REG_MATCH_THRESHOLD = 3'd5
    } t_reg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [REG_WORDS-1:0][WORD_BITS-1:0] code_word;
        logic [LEN_W-1:0]                    code_length;
        logic [LEN_W-1:0]                    match_threshold;
    } t_cfg;

    // Per-chunk mismatch counts handed from the count stage to the sum stage
    typedef logic [NUM_CHUNKS-1:0][CHUNK_CNT_W-1:0] t_chunk_cnt_vec;

    // Ones count of a 16-bit chunk: four nibble counts, then their sum
    function automatic logic [CHUNK_CNT_W-1:0] chunk_ones(input logic [CHUNK_BITS-1:0] v);
        logic [2:0] nib [4];
        for (int n = 0; n < 4; n++) begin
            nib[n] = {2'b00, v[4*n]} + {2'b00, v[4*n+1]}
                   + {2'b00, v[4*n+2]} + {2'b00, v[4*n+3]};
        end
        return CHUNK_CNT_W'(({2'b00, nib[0]} + {2'b00, nib[1]})
                          + ({2'b00, nib[2]} + {2'b00, nib[3]}));
    endfunction

endpackage

[sv/lacc_cfg_regs.sv]
// Configuration register file: access code words, code length and threshold.
module lacc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lacc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lacc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lacc_pkg::t_cfg                      o_cfg
);
    import lacc_pkg::*;

    t_cfg r_cfg;

    // Register writes; indexes past the map are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_word       <= '0;
            r_cfg.code_length     <= CODE_LENGTH_RST;
            r_cfg.match_threshold <= MATCH_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CODE_WORD_0:     r_cfg.code_word[0] <= i_cfg_data;
                REG_CODE_WORD_1:     r_cfg.code_word[1] <= i_cfg_data;
                REG_CODE_WORD_2:     r_cfg.code_word[2] <= i_cfg_data;
                REG_CODE_WORD_3:     r_cfg.code_word[3] <= i_cfg_data;
                REG_CODE_LENGTH:     r_cfg.code_length     <= i_cfg_data[LEN_W-1:0];
                REG_MATCH_THRESHOLD: r_cfg.match_threshold <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/lacc_hist_count.sv]
// Bit history shift register and registered per-chunk mismatch counts.
module lacc_hist_count (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_bit,
    input  lacc_pkg::t_cfg           i_cfg,
    output lacc_pkg::t_chunk_cnt_vec o_chunk_cnt
);
    import lacc_pkg::*;

    logic [HIST_BITS-1:0] r_hist;
    logic [HIST_BITS-1:0] n_hist;
    logic [HIST_BITS-1:0] code_flat;
    logic [HIST_BITS-1:0] len_mask;
    logic [HIST_BITS-1:0] diff;
    t_chunk_cnt_vec       r_chunk_cnt;
    t_chunk_cnt_vec       n_chunk_cnt;

    // Newest bit enters at position 0, oldest falls off the top
    assign n_hist    = {r_hist[HIST_BITS-2:0], i_bit};
    assign code_flat = i_cfg.code_word[CODE_WORDS-1:0];

    // Compare only positions below code_length (longer lengths saturate)
    always_comb begin
        for (int p = 0; p < HIST_BITS; p++) begin
            len_mask[p] = (LEN_W'(p) < i_cfg.code_length);
        end
    end

    assign diff = (n_hist ^ code_flat) & len_mask;

    // Count mismatches per chunk
    always_comb begin
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            n_chunk_cnt[c] = chunk_ones(diff[c*CHUNK_BITS +: CHUNK_BITS]);
        end
    end

    // History is control state; counts are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_accept) begin
            r_hist <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_chunk_cnt <= n_chunk_cnt;
        end
    end

    assign o_chunk_cnt = r_chunk_cnt;

    // History shifts exactly on a transfer
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_hist[0] == $past(i_bit))
                     && (r_hist[HIST_BITS-1:1] == $past(r_hist[HIST_BITS-2:0])))
        else $error("history did not shift on input transfer");

    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_accept |=> $stable(r_hist))
        else $error("history changed without input transfer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_accept) && $past(i_rst_n) |-> (r_chunk_cnt[0] <= CHUNK_CNT_W'(CHUNK_BITS)))
        else $error("chunk count out of range");

endmodule

[sv/lacc_sum_cmp.sv]
// Adder tree over the chunk counts and threshold compare.
module lacc_sum_cmp (
    input  lacc_pkg::t_chunk_cnt_vec         i_chunk_cnt,
    input  logic [lacc_pkg::LEN_W-1:0]       i_threshold,
    output logic                             o_match
);
    import lacc_pkg::*;

    logic [CNT_W-1:0] acc [NUM_CHUNKS];

    // Pairwise reduction, log2 levels deep
    always_comb begin
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            acc[i] = CNT_W'(i_chunk_cnt[i]);
        end
        for (int s = 1; s < NUM_CHUNKS; s = s * 2) begin
            for (int i = 0; i < NUM_CHUNKS; i = i + 2 * s) begin
                if (i + s < NUM_CHUNKS) begin
                    acc[i] = acc[i] + acc[i+s];
                end
            end
        end
    end

    // Strictly below threshold
    assign o_match = ((LEN_W + 1)'(acc[0]) < (LEN_W + 1)'(i_threshold));

endmodule

[sv/long_access_code_correlator_unit.sv]
// Top level: long access code correlator with Hamming distance threshold.
// A result is valid once its input transfer has passed the count stage and the output register.
// Throughput: one bit per cycle; the count stage and output register both
// advance every cycle unless the output side stalls.
// Reset (synchronous, active low) clears the history, the pipeline valids and
// loads the register reset values (code 0, length 64, threshold 0).
module long_access_code_correlator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lacc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lacc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_in_bit,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_data_bit,
    output logic                              o_match_flag
);
    import lacc_pkg::*;

    t_cfg           cfg;
    t_chunk_cnt_vec chunk_cnt;
    logic           match;
    logic           in_xfer;
    logic           out_move;
    logic           r_s1_valid;
    logic           r_s1_bit;
    logic           r_out_valid;
    logic           r_out_bit;
    logic           r_out_flag;

    lacc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: output register frees when empty or being taken
    assign out_move   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_move;
    assign in_xfer    = i_in_valid && !o_in_stall;

    lacc_hist_count u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_bit       (i_in_bit),
        .i_cfg       (cfg),
        .o_chunk_cnt (chunk_cnt)
    );

    lacc_sum_cmp u_sum (
        .i_chunk_cnt (chunk_cnt),
        .i_threshold (cfg.match_threshold),
        .o_match     (match)
    );

    // Count stage valid and passthrough bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (out_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_bit <= i_in_bit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_s1_valid) begin
            r_out_bit  <= r_s1_bit;
            r_out_flag <= match;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_bit   = r_out_bit;
    assign o_match_flag = r_out_flag;

    // A transfer always fills the count stage
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && in_xfer |=> r_s1_valid)
        else $error("count stage empty after input transfer");

    // Both stages full and output stalled must back-pressure the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_out_stall |-> o_in_stall)
        else $error("input not stalled with full pipeline");

    // Output drains when nothing is behind it
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && out_move && !r_s1_valid |=> !r_out_valid)
        else $error("output valid without a source");

    // Passthrough bit follows the count stage into the output
    a_bit_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && out_move && r_s1_valid |=> (r_out_bit == $past(r_s1_bit)))
        else $error("data bit lost between stages");

endmodule
